[src/gohist_pkg.sv]
// ----------------------------------------------------------------------------
// Gradient orientation histogram package
// Shared widths, register codes, payload structs and divider result struct.
// ----------------------------------------------------------------------------
package gohist_pkg;

  localparam int ORIENT_W = 13;
  localparam int ANGLE_W  = 9;
  localparam int MAG_W    = 16;
  localparam int SUM_W    = 48;
  localparam int IDX_W    = 6;
  localparam int SPAN_W   = 11;
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 3;

  // Restoring divider: quotient bits produced per clock cycle.
  localparam int DIV_STEP   = 3;
  localparam int DIV_CYCLES = ANGLE_W / DIV_STEP;

  localparam int MAX_BINS_DEF = 64;

  localparam logic [ANGLE_W-1:0] MIN_WIDTH   = 9'd6;
  localparam logic [ANGLE_W-1:0] WIDTH_RESET = 9'd20;
  localparam logic [ANGLE_W-1:0] SPAN_FULL   = 9'd360;
  localparam logic [ANGLE_W-1:0] SPAN_HALF   = 9'd180;

  // Register codes, decoded from paddr[2].
  localparam logic REG_BIN_WIDTH   = 1'b0;
  localparam logic REG_HALF_CIRCLE = 1'b1;

  typedef struct packed {
    logic [ORIENT_W-1:0] orient_deg;
    logic [MAG_W-1:0]    grad_mag;
    logic                in_mask;
    logic                frame_end;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] bin_index;
    logic [SUM_W-1:0] bin_sum;
    logic             last_bin;
  } out_item_t;

  typedef struct packed {
    logic               done;
    logic [ANGLE_W-1:0] quot;
    logic [ANGLE_W-1:0] rem;
  } div_res_t;

endpackage

[src/gohist_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gohist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/gohist_div.sv]
// ----------------------------------------------------------------------------
// Angle divider
// Restoring divider for the integer angle by the bin width, several quotient
// bits per cycle.
// ----------------------------------------------------------------------------
module gohist_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [gohist_pkg::ANGLE_W-1:0]  dividend,
  input  logic [gohist_pkg::ANGLE_W-1:0]  divisor,
  output gohist_pkg::div_res_t            res
);

  localparam int CW = $clog2(gohist_pkg::DIV_CYCLES + 1);

  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic                            done_r, done_nxt;
  logic [gohist_pkg::ANGLE_W-1:0]  sh_r, sh_nxt;
  logic [gohist_pkg::ANGLE_W-1:0]  rem_r, rem_nxt;
  logic [gohist_pkg::ANGLE_W-1:0]  dvs_r;

  always_comb begin
    logic [gohist_pkg::ANGLE_W:0]   rt;
    logic [gohist_pkg::ANGLE_W-1:0] sh;
    logic [gohist_pkg::ANGLE_W-1:0] rm;
    logic                           ge;
    rt       = '0;
    ge       = 1'b0;
    sh       = sh_r;
    rm       = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (cnt_r != '0) begin
      for (int k = 0; k < gohist_pkg::DIV_STEP; k++) begin
        rt = {rm, sh[gohist_pkg::ANGLE_W-1]};
        ge = (rt >= {1'b0, dvs_r});
        if (ge) begin
          rt = rt - {1'b0, dvs_r};
        end
        rm = rt[gohist_pkg::ANGLE_W-1:0];
        sh = {sh[gohist_pkg::ANGLE_W-2:0], ge};
      end
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
    sh_nxt  = sh;
    rem_nxt = rm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CW'(gohist_pkg::DIV_CYCLES);
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else begin
      sh_r  <= sh_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign res.done = done_r;
  assign res.quot = sh_r;
  assign res.rem  = rem_r;

endmodule

[src/gradient_orientation_histogram_core.sv]
// ----------------------------------------------------------------------------
// Gradient orientation histogram core
// Bins pixel gradient magnitudes by orientation into a saturating histogram
// held in one RAM, and reads the histogram out at each end-of-frame pixel.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------------------------
//  pixel in | start, busy                | in_data  (orient, magnitude, mask,
//           |                            |           frame end)
//  bins out | out_valid (strobe)         | out_data (bin index, sum, last)
//  config   | psel, penable, pwrite,     | paddr, pwdata, prdata
//           | pready (always high)       |
//
// A pixel transaction that updates a bin passes through the angle divider (its
// iteration steps, then a flag on the quotient), a RAM read, an add and write,
// and the idle state in which the next pixel is accepted; a masked or dropped
// pixel skips the RAM read and the write. The end-of-frame pixel then streams
// the bins out, one per cycle.
// Reset clears the control state and marks every bin empty at once; the RAM
// itself holds no reset value. Results cannot be stalled by the receiver.
//
// The integer angle (orientation with its four fraction bits dropped) is folded
// modulo 180 in half-circle mode and divided by the effective bin width, which
// is the programmed width but at least six degrees. The divider remainder gives
// quotient times width for free, so a pixel lands inside the bin range when that
// product plus one width does not pass the span (180 or 360). The same running
// product drives the last-bin test during readout.
//
// Every entry carries a valid bit. An empty entry reads as zero, so clearing the
// whole store after a readout is only a reset of the valid bits.
// ----------------------------------------------------------------------------
module gradient_orientation_histogram_core #(
  parameter int MAX_BINS = gohist_pkg::MAX_BINS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Pixel input
  input  logic                           start,
  output logic                           busy,
  input  gohist_pkg::in_item_t           in_data,
  // Bin readout
  output logic                           out_valid,
  output gohist_pkg::out_item_t          out_data,
  // Configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gohist_pkg::CFG_AW-1:0]  paddr,
  input  logic [gohist_pkg::CFG_DW-1:0]  pwdata,
  output logic [gohist_pkg::CFG_DW-1:0]  prdata,
  output logic                           pready
);

  localparam int AW = $clog2(MAX_BINS);
  localparam int AW_EXT = 10;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_RD   = 5'b00100,
    ST_WR   = 5'b01000,
    ST_RO   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [gohist_pkg::ANGLE_W-1:0] width_r;
  logic                           half_r;

  // Pixel payload captured at acceptance.
  logic [gohist_pkg::MAG_W-1:0]   mag_r;
  logic                           mask_r;
  logic                           end_r;
  logic [gohist_pkg::ANGLE_W-1:0] ang_r;

  // Bin update and readout bookkeeping.
  logic [AW-1:0]                  bin_r, bin_nxt;
  logic                           hit_vld_r, hit_vld_nxt;
  logic [MAX_BINS-1:0]            vbits_r, vbits_nxt;
  logic [AW-1:0]                  ro_idx_r, ro_idx_nxt;
  logic [gohist_pkg::SPAN_W-1:0]  ro_acc_r, ro_acc_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [AW-1:0]                  out_idx_r, out_idx_nxt;
  logic                           out_last_r, out_last_nxt;
  logic                           out_vld_r, out_vld_nxt;

  logic                           accept;
  logic                           cfg_wr;
  logic [gohist_pkg::ANGLE_W-1:0] w_eff;
  logic [gohist_pkg::ANGLE_W-1:0] span;
  logic [gohist_pkg::ANGLE_W-1:0] ang_in;
  logic [gohist_pkg::ANGLE_W-1:0] ang_fold;
  gohist_pkg::div_res_t           div_res;

  logic                           ram_we;
  logic [AW-1:0]                  ram_raddr;
  logic [gohist_pkg::SUM_W-1:0]   ram_rdata;
  logic [gohist_pkg::SUM_W-1:0]   ram_wdata;

  logic [gohist_pkg::SPAN_W-1:0]  prod_next;
  logic                           hit;
  logic                           ro_none;
  logic                           ro_last;
  logic [gohist_pkg::SUM_W:0]     sum_ext;
  logic [gohist_pkg::SUM_W-1:0]   base;
  logic [AW_EXT-1:0]              idx_ext;

  // --------------------------------------------------------------------------
  // Configuration port: registers are selected by paddr[2].
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= gohist_pkg::WIDTH_RESET;
      half_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        gohist_pkg::REG_BIN_WIDTH:   width_r <= pwdata[gohist_pkg::ANGLE_W-1:0];
        gohist_pkg::REG_HALF_CIRCLE: half_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      gohist_pkg::REG_BIN_WIDTH:
        prdata = {{(gohist_pkg::CFG_DW-gohist_pkg::ANGLE_W){1'b0}}, width_r};
      gohist_pkg::REG_HALF_CIRCLE:
        prdata = {{(gohist_pkg::CFG_DW-1){1'b0}}, half_r};
      default:
        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Angle preparation: drop the fraction, fold modulo 180 in half-circle mode.
  // The integer angle stays below three half turns, so two compares suffice.
  // --------------------------------------------------------------------------
  assign w_eff  = (width_r < gohist_pkg::MIN_WIDTH) ? gohist_pkg::MIN_WIDTH : width_r;
  assign span   = half_r ? gohist_pkg::SPAN_HALF : gohist_pkg::SPAN_FULL;
  assign ang_in = in_data.orient_deg[gohist_pkg::ORIENT_W-1:4];

  always_comb begin
    if (ang_in >= gohist_pkg::SPAN_FULL) begin
      ang_fold = ang_in - gohist_pkg::SPAN_FULL;
    end else if (ang_in >= gohist_pkg::SPAN_HALF) begin
      ang_fold = ang_in - gohist_pkg::SPAN_HALF;
    end else begin
      ang_fold = ang_in;
    end
  end

  assign busy   = (state_r != ST_IDLE);
  assign accept = start & ~busy;

  gohist_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (half_r ? ang_fold : ang_in),
    .divisor  (w_eff),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r  <= in_data.grad_mag;
      mask_r <= in_data.in_mask;
      end_r  <= in_data.frame_end;
      ang_r  <= half_r ? ang_fold : ang_in;
    end
  end

  // --------------------------------------------------------------------------
  // Range test: quotient * width equals angle minus remainder.
  // --------------------------------------------------------------------------
  assign prod_next = {2'b00, ang_r} - {2'b00, div_res.rem} + {2'b00, w_eff};
  assign hit = mask_r
             && ({1'b0, div_res.quot} < AW_EXT'(MAX_BINS))
             && (prod_next <= {2'b00, span});

  // A width wider than the span leaves no bins at all.
  assign ro_none = (w_eff > span);
  assign ro_last = ((ro_acc_r + {2'b00, w_eff}) > {2'b00, span})
                || (ro_idx_r == AW'(MAX_BINS - 1));

  // Saturating accumulate of the entry read in the previous cycle.
  assign base    = hit_vld_r ? ram_rdata : '0;
  assign sum_ext = {1'b0, base} + (gohist_pkg::SUM_W + 1)'(mag_r);
  assign ram_wdata = sum_ext[gohist_pkg::SUM_W] ? {gohist_pkg::SUM_W{1'b1}}
                                                : sum_ext[gohist_pkg::SUM_W-1:0];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    hit_vld_nxt   = hit_vld_r;
    vbits_nxt     = vbits_r;
    ro_idx_nxt    = ro_idx_r;
    ro_acc_nxt    = ro_acc_r;
    out_valid_nxt = 1'b0;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    out_vld_nxt   = out_vld_r;
    ram_we        = 1'b0;
    ram_raddr     = bin_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_res.done) begin
          bin_nxt = div_res.quot[AW-1:0];
          if (hit) begin
            state_nxt = ST_RD;
          end else if (end_r) begin
            ro_idx_nxt = '0;
            ro_acc_nxt = {2'b00, w_eff};
            if (ro_none) begin
              vbits_nxt = '0;
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_RO;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_RD: begin
        ram_raddr   = bin_r;
        hit_vld_nxt = vbits_r[bin_r];
        state_nxt   = ST_WR;
      end

      ST_WR: begin
        ram_we         = 1'b1;
        vbits_nxt[bin_r] = 1'b1;
        if (end_r) begin
          ro_idx_nxt = '0;
          ro_acc_nxt = {2'b00, w_eff};
          if (ro_none) begin
            vbits_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_RO;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_RO: begin
        ram_raddr     = ro_idx_r;
        out_valid_nxt = 1'b1;
        out_idx_nxt   = ro_idx_r;
        out_vld_nxt   = vbits_r[ro_idx_r];
        out_last_nxt  = ro_last;
        if (ro_last) begin
          vbits_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          ro_idx_nxt = ro_idx_r + AW'(1);
          ro_acc_nxt = ro_acc_r + {2'b00, w_eff};
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vbits_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vbits_r     <= vbits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    hit_vld_r  <= hit_vld_nxt;
    ro_idx_r   <= ro_idx_nxt;
    ro_acc_r   <= ro_acc_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
    out_vld_r  <= out_vld_nxt;
  end

  gohist_ram #(
    .WIDTH (gohist_pkg::SUM_W),
    .DEPTH (MAX_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bin_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Readout transaction: RAM data arrives in the cycle after its address.
  // --------------------------------------------------------------------------
  assign idx_ext            = AW_EXT'(out_idx_r);
  assign out_valid          = out_valid_r;
  assign out_data.bin_index = idx_ext[gohist_pkg::IDX_W-1:0];
  assign out_data.bin_sum   = out_vld_r ? ram_rdata : '0;
  assign out_data.last_bin  = out_last_r;

endmodule

[tb/sv/gradient_orientation_histogram_core_tb.sv]
// ----------------------------------------------------------------------------
// Gradient orientation histogram core testbench
// Drives pixel transactions and register writes into the core. A model of the
// histogram in this file predicts every bin readout, and each result
// transaction is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module gradient_orientation_histogram_core_tb;
  import gohist_pkg::*;

  localparam int HIST_BINS     = MAX_BINS_DEF;
  // Pause before a register write. It covers a pixel that is still being
  // binned when the last readout result has already arrived.
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PIXELS = 120;
  localparam int IDLE_PERCENT  = 14;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_item_t            in_data;
  logic                out_valid;
  out_item_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  // Model of the histogram: the bin store and the two registers as the core
  // should hold them after every accepted transaction.
  logic [SUM_W-1:0]    bin_acc [HIST_BINS];
  logic [ANGLE_W-1:0]  cfg_width;
  logic                cfg_half;
  // Bin readouts predicted but not yet seen on the result port, oldest first.
  out_item_t           expected_bins [$];

  int                  mismatches = 0;
  int                  cycle_count = 0;
  // Set while the sender must run back to back without idle cycles.
  bit                  quiet_sender = 1'b0;

  gradient_orientation_histogram_core #(
    .MAX_BINS (HIST_BINS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Histogram model
  // --------------------------------------------------------------------------

  // Widths below the minimum are clamped, which keeps the readout at no more than 60 bins.
  function automatic int unsigned effective_width();
    return (cfg_width < MIN_WIDTH) ? int'(MIN_WIDTH) : int'(cfg_width);
  endfunction

  // Number of bins that fit in the span. Widths wider than the span give zero.
  function automatic int unsigned bins_in_range();
    int unsigned span;
    int unsigned n;
    span = cfg_half ? int'(SPAN_HALF) : int'(SPAN_FULL);
    n = span / effective_width();
    if (n > HIST_BINS) n = HIST_BINS;
    return n;
  endfunction

  // In half-circle mode the integer angle is folded before the division, so
  // orientations past 360 degrees still land in a bin. In full-circle mode
  // they fall beyond the bin count and are dropped.
  function automatic int unsigned orientation_bin(input logic [ORIENT_W-1:0] orient);
    int unsigned angle16;
    angle16 = orient;
    if (cfg_half) return ((angle16 >> 4) % 180) / effective_width();
    return angle16 / (16 * effective_width());
  endfunction

  // Appends one predicted bin readout behind the ones already waiting.
  function automatic void add_expected_bin(input out_item_t item);
    expected_bins = {expected_bins, item};
  endfunction

  // Applies one accepted pixel to the model. Registers in force right now pick
  // the bin; an end-of-frame pixel is counted first and then queues one
  // readout per bin before the whole store is cleared.
  function automatic void histogram_update(input in_item_t px);
    int unsigned    n;
    int unsigned    b;
    logic [SUM_W:0] total;
    out_item_t      res;
    n = bins_in_range();
    if (px.in_mask) begin
      b = orientation_bin(px.orient_deg);
      if (b < n) begin
        total = {1'b0, bin_acc[b]} + px.grad_mag;
        bin_acc[b] = total[SUM_W] ? '1 : total[SUM_W-1:0];
      end
    end
    if (px.frame_end) begin
      for (int unsigned i = 0; i < n; i++) begin
        res.bin_index = IDX_W'(i);
        res.bin_sum   = bin_acc[i];
        res.last_bin  = (i + 1 == n);
        add_expected_bin(res);
      end
      foreach (bin_acc[k]) bin_acc[k] = '0;
    end
  endfunction

  function automatic void note_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    if (mismatches < 10)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    mismatches++;
  endfunction

  function automatic in_item_t make_pixel(input int unsigned orient,
                                          input int unsigned mag,
                                          input bit mask, input bit fend);
    in_item_t px;
    px.orient_deg = ORIENT_W'(orient);
    px.grad_mag   = MAG_W'(mag);
    px.in_mask    = mask;
    px.frame_end  = fend;
    return px;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker. The receiver cannot stall the core, so every cycle with
  // the strobe high is one result transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : bin_checker
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_bins.size() == 0) begin
        note_mismatch("unexpected bin transaction", '0, out_data);
      end else begin
        want = expected_bins.pop_front();
        if (out_data.bin_index !== want.bin_index)
          note_mismatch("bin_index", want.bin_index, out_data.bin_index);
        if (out_data.bin_sum !== want.bin_sum)
          note_mismatch("bin_sum", want.bin_sum, out_data.bin_sum);
        if (out_data.last_bin !== want.last_bin)
          note_mismatch("last_bin", want.last_bin, out_data.last_bin);
      end
    end
  end

  // Watchdog: a hung handshake or a readout that never comes ends the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Transaction tasks. Each one is entered just after a rising edge and
  // returns just after one, so every input gets at most one nonblocking
  // assignment per time step.
  // --------------------------------------------------------------------------

  // Offers one pixel and waits until the core takes it. The start strobe is
  // left high on return so that back-to-back pixels follow without a gap.
  task automatic send_pixel(input in_item_t px);
    if (!quiet_sender && $urandom_range(99) < IDLE_PERCENT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    histogram_update(px);
  endtask

  // Register read, checked against the model. It closes the bus afterwards
  // and leaves it idle before returning.
  task automatic read_register(input logic reg_code);
    logic [CFG_DW-1:0] want;
    want = (reg_code == REG_BIN_WIDTH) ? CFG_DW'(cfg_width) : CFG_DW'(cfg_half);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_code, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want)
      note_mismatch(reg_code == REG_BIN_WIDTH ? "bin width readback" : "half circle readback",
                    want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Register write, always followed directly by a readback of the same
  // register as the next bus transaction.
  task automatic write_register(input logic reg_code, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_code, 2'b00};
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (reg_code)
      REG_BIN_WIDTH:   cfg_width = ANGLE_W'(value);
      REG_HALF_CIRCLE: cfg_half  = value[0];
      default: ;
    endcase
    read_register(reg_code);
  endtask

  // Waits until every predicted bin has come out and the core has gone idle,
  // then lets the pipeline drain before anything touches the registers.
  task automatic settle_block();
    start <= 1'b0;
    @(posedge clk);
    while (expected_bins.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned width, input bit half);
    settle_block();
    write_register(REG_BIN_WIDTH, width);
    write_register(REG_HALF_CIRCLE, half);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values, then field extremes with the reset configuration (20 degree
  // bins over the full circle). Orientations of 360 degrees and beyond must be
  // dropped, a masked pixel adds nothing, and a masked end-of-frame pixel still
  // triggers the readout. Saturation of a bin would need billions of pixels,
  // so only the model covers it.
  task automatic test_default_extremes();
    read_register(REG_BIN_WIDTH);
    read_register(REG_HALF_CIRCLE);
    send_pixel(make_pixel(0, 16'hFFFF, 1'b1, 1'b0));
    send_pixel(make_pixel(5759, 1, 1'b1, 1'b0));
    send_pixel(make_pixel(5760, 16'hFFFF, 1'b1, 1'b0));
    send_pixel(make_pixel(8191, 16'h1234, 1'b1, 1'b0));
    send_pixel(make_pixel(320, 16'hFFFF, 1'b0, 1'b0));
    send_pixel(make_pixel(16 * 359, 16'h8000, 1'b0, 1'b1));
  endtask

  // Half-circle folding with the narrowest bins: angles at and beyond 180
  // degrees, including the largest orientation code, wrap around.
  task automatic test_half_circle_fold();
    set_config(6, 1'b1);
    send_pixel(make_pixel(8191, 16'hFFFF, 1'b1, 1'b0));
    send_pixel(make_pixel(2880, 16'h00FF, 1'b1, 1'b0));
    send_pixel(make_pixel(2879, 16'h5555, 1'b1, 1'b0));
    send_pixel(make_pixel(16, 16'hAAAA, 1'b1, 1'b1));
  endtask

  // Widths below six degrees behave as six: a 60-bin readout.
  task automatic test_narrowest_bins();
    set_config(0, 1'b0);
    send_pixel(make_pixel(5759, 7, 1'b1, 1'b0));
    send_pixel(make_pixel(0, 9, 1'b1, 1'b1));
    set_config(5, 1'b0);
    send_pixel(make_pixel(96, 3, 1'b1, 1'b1));
  endtask

  // Widths wider than the span leave no bins: pixels are dropped and the end
  // mark produces nothing but still clears the store. The following one-bin
  // readout shows that the store really is empty.
  task automatic test_empty_bin_range();
    set_config(361, 1'b0);
    send_pixel(make_pixel(0, 100, 1'b1, 1'b0));
    send_pixel(make_pixel(4000, 100, 1'b1, 1'b1));
    set_config(360, 1'b0);
    send_pixel(make_pixel(100, 0, 1'b0, 1'b1));
    set_config(511, 1'b1);
    send_pixel(make_pixel(1600, 5, 1'b1, 1'b1));
    set_config(180, 1'b1);
    send_pixel(make_pixel(0, 0, 1'b0, 1'b1));
  endtask

  // A register change inside a frame: earlier pixels keep their old bins, the
  // readout uses the new bin count and the bin beyond it is lost to the clear.
  task automatic test_config_mid_frame();
    set_config(20, 1'b0);
    send_pixel(make_pixel(1600, 300, 1'b1, 1'b0));
    set_config(45, 1'b1);
    send_pixel(make_pixel(3200, 400, 1'b1, 1'b0));
    send_pixel(make_pixel(16 * 179, 11, 1'b1, 1'b1));
  endtask

  // Random frames of one to ten pixels, each closed by an end mark, with a new
  // configuration every third frame. Most widths give real bins; some are
  // clamped or wider than the span. A stretch in the middle runs without idle
  // cycles on the sender.
  task automatic test_random_frames();
    int          sent;
    int          frame;
    int          len;
    int unsigned width;
    int unsigned orient;
    int unsigned mag;
    sent  = 0;
    frame = 0;
    while (sent < RANDOM_PIXELS) begin
      if (frame % 3 == 0) begin
        case ($urandom_range(9))
          0:       width = $urandom_range(5);
          1:       width = $urandom_range(181, 511);
          2:       width = 360;
          default: width = $urandom_range(6, 180);
        endcase
        set_config(width, $urandom_range(1));
      end
      len = $urandom_range(1, 10);
      for (int p = 0; p < len; p++) begin
        quiet_sender = (sent >= 40 && sent < 75);
        orient = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(5759);
        case ($urandom_range(9))
          0:       mag = 0;
          1:       mag = 16'hFFFF;
          default: mag = $urandom_range(16'hFFFF);
        endcase
        send_pixel(make_pixel(orient, mag, $urandom_range(99) < 85, p == len - 1));
        sent++;
      end
      frame++;
    end
    quiet_sender = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    start   <= 1'b0;
    in_data <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_n   <= 1'b0;
    foreach (bin_acc[k]) bin_acc[k] = '0;
    cfg_width = WIDTH_RESET;
    cfg_half  = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_extremes();
    test_half_circle_fold();
    test_narrowest_bins();
    test_empty_bin_range();
    test_config_mid_frame();
    test_random_frames();

    // Every prediction must be met before the verdict; a missing readout
    // keeps this waiting until the watchdog fires.
    settle_block();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
